// File: hdl/i2c_master_byte_engine_assert.svh
// assertion macros for the i2c master byte engine
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, disabled while reset is held
`define I2CM_ASSERT_IMPL(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("i2cm assertion failed");
// next-cycle implication, disabled while reset is held
`define I2CM_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("i2cm assertion failed");
`else
`define I2CM_ASSERT_IMPL(lbl, clk, rstn, a, b)
`define I2CM_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif

`endif

// File: hdl/i2cm_pkg.sv
// types and constants for the i2c master byte engine
`timescale 1ns / 1ps

package i2cm_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LOW  = 3'b010,
        PH_HIGH = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    localparam logic [0:0] REG_LOW_TICKS  = 1'b0;
    localparam logic [0:0] REG_HIGH_TICKS = 1'b1;

    localparam logic [7:0] LOW_TICKS_RESET  = 8'd3;
    localparam logic [7:0] HIGH_TICKS_RESET = 8'd2;

    // slot number of the ack bit after the eight data bits
    localparam logic [3:0] ACK_SLOT = 4'd8;
    localparam logic [7:0] MSB_MASK = 8'h80;

endpackage

// File: hdl/i2c_master_byte_engine.sv
// i2c master byte engine: one bus tick per item, registered result per tick
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | operation, tx_byte, ack_to_send, sda_in
//   m_      | out       | m_valid / m_ready  | scl, sda, busy, done, rx_byte, ack, rejected
//   cfg_    | in        | cfg_we             | cfg_index, cfg_data
//
// one item is taken per cycle while s_ready is high; its result appears in the output register in the next cycle
// the sequencer state and the output register update in the same edge, so throughput is
// one item per cycle as long as the result side keeps taking
// s_ready drops only while a result waits and m_ready is low
// reset is synchronous, active low; it restores bus release and the default delays
`timescale 1ns / 1ps

module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_operation,
    input  logic [7:0] s_tx_byte,
    input  logic       s_ack_to_send,
    input  logic       s_sda_in,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_out,
    output logic       m_sda_out,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_rx_byte,
    output logic       m_ack_received,
    output logic       m_rejected
);

`include "i2c_master_byte_engine_assert.svh"

    logic [7:0] low_ticks_reg;
    logic [7:0] high_ticks_reg;

    phase_t     phase_reg,       phase_next;
    logic [7:0] tick_count_reg,  tick_count_next;
    logic [3:0] bit_index_reg,   bit_index_next;
    logic [7:0] shift_data_reg,  shift_data_next;
    op_t        current_op_reg,  current_op_next;
    logic       scl_level_reg,   scl_level_next;
    logic       sda_level_reg,   sda_level_next;
    logic       ack_level_reg,   ack_level_next;
    logic [7:0] read_result_reg, read_result_next;
    logic       ack_choice_reg,  ack_choice_next;

    logic       m_valid_reg;
    logic       scl_out_reg;
    logic       sda_out_reg;
    logic       busy_reg;
    logic       done_reg;
    logic [7:0] rx_byte_reg;
    logic       ack_out_reg;
    logic       rejected_reg;

    logic       accept;
    logic       is_cmd;
    op_t        op_in;
    logic [7:0] low_lim;
    logic [7:0] high_lim;
    logic [7:0] tick_inc;
    logic [3:0] next_bit;
    logic       next_sda;
    logic       rej_c;
    logic       done_c;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // a zero delay behaves as one tick
    assign low_lim  = (low_ticks_reg == 8'd0) ? 8'd1 : low_ticks_reg;
    assign high_lim = (high_ticks_reg == 8'd0) ? 8'd1 : high_ticks_reg;
    assign tick_inc = tick_count_reg + 8'd1;
    assign next_bit = bit_index_reg + 4'd1;

    always_comb begin
        op_in  = OP_TICK;
        is_cmd = 1'b0;
        unique case (s_operation)
            OP_START: begin op_in = OP_START; is_cmd = 1'b1; end
            OP_STOP:  begin op_in = OP_STOP;  is_cmd = 1'b1; end
            OP_WRITE: begin op_in = OP_WRITE; is_cmd = 1'b1; end
            OP_READ:  begin op_in = OP_READ;  is_cmd = 1'b1; end
            default:  begin op_in = OP_TICK;  is_cmd = 1'b0; end
        endcase
    end

    // sda level at the start of the following slot
    always_comb begin
        next_sda = 1'b0;
        if (current_op_reg == OP_WRITE) begin
            if (next_bit < ACK_SLOT) begin
                next_sda = shift_data_reg[3'(4'd7 - next_bit)];
            end else begin
                next_sda = 1'b1;
            end
        end else begin
            next_sda = (next_bit < ACK_SLOT) ? 1'b1 : ack_choice_reg;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        bit_index_next   = bit_index_reg;
        shift_data_next  = shift_data_reg;
        current_op_next  = current_op_reg;
        scl_level_next   = scl_level_reg;
        sda_level_next   = sda_level_reg;
        ack_level_next   = ack_level_reg;
        read_result_next = read_result_reg;
        ack_choice_next  = ack_choice_reg;
        rej_c            = 1'b0;
        done_c           = 1'b0;

        if (accept) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (is_cmd) begin
                        current_op_next = op_in;
                        bit_index_next  = 4'd0;
                        tick_count_next = 8'd0;
                        phase_next      = PH_LOW;
                        if (op_in == OP_WRITE) begin
                            shift_data_next = s_tx_byte;
                            sda_level_next  = s_tx_byte[7];
                        end else if (op_in == OP_READ) begin
                            shift_data_next = 8'd0;
                            ack_choice_next = s_ack_to_send;
                            sda_level_next  = 1'b1;
                        end
                    end
                end
                PH_LOW: begin
                    rej_c           = is_cmd;
                    tick_count_next = tick_inc;
                    if (tick_inc >= low_lim) begin
                        if (current_op_reg == OP_START) begin
                            sda_level_next = 1'b0;
                        end else begin
                            scl_level_next = 1'b1;
                            // read data is sampled as scl rises
                            if (current_op_reg == OP_READ && bit_index_reg < ACK_SLOT
                                    && s_sda_in) begin
                                shift_data_next = shift_data_reg
                                                | (MSB_MASK >> bit_index_reg[2:0]);
                            end
                        end
                        tick_count_next = 8'd0;
                        phase_next      = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    rej_c           = is_cmd;
                    tick_count_next = tick_inc;
                    if (tick_inc >= high_lim) begin
                        tick_count_next = 8'd0;
                        if (current_op_reg == OP_START) begin
                            scl_level_next = 1'b0;
                            done_c         = 1'b1;
                        end else if (current_op_reg == OP_STOP) begin
                            sda_level_next = 1'b1;
                            done_c         = 1'b1;
                        end else begin
                            scl_level_next = 1'b0;
                            sda_level_next = 1'b0;
                            if (bit_index_reg >= ACK_SLOT) begin
                                if (current_op_reg == OP_WRITE) begin
                                    ack_level_next = s_sda_in;
                                end else begin
                                    read_result_next = shift_data_reg;
                                end
                                done_c = 1'b1;
                            end else begin
                                // end of one slot sets sda for the next
                                bit_index_next = next_bit;
                                sda_level_next = next_sda;
                                phase_next     = PH_LOW;
                            end
                        end
                        if (done_c) begin
                            phase_next     = PH_IDLE;
                            bit_index_next = 4'd0;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_ticks_reg   <= LOW_TICKS_RESET;
            high_ticks_reg  <= HIGH_TICKS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LOW_TICKS:  low_ticks_reg  <= cfg_data;
                REG_HIGH_TICKS: high_ticks_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= 8'd0;
            bit_index_reg   <= 4'd0;
            shift_data_reg  <= 8'd0;
            current_op_reg  <= OP_TICK;
            scl_level_reg   <= 1'b1;
            sda_level_reg   <= 1'b1;
            ack_level_reg   <= 1'b0;
            read_result_reg <= 8'd0;
            ack_choice_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            bit_index_reg   <= bit_index_next;
            shift_data_reg  <= shift_data_next;
            current_op_reg  <= current_op_next;
            scl_level_reg   <= scl_level_next;
            sda_level_reg   <= sda_level_next;
            ack_level_reg   <= ack_level_next;
            read_result_reg <= read_result_next;
            ack_choice_reg  <= ack_choice_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result register, loaded with the state after this tick
    always_ff @(posedge aclk) begin
        if (accept) begin
            scl_out_reg  <= scl_level_next;
            sda_out_reg  <= sda_level_next;
            busy_reg     <= (phase_next != PH_IDLE);
            done_reg     <= done_c;
            rx_byte_reg  <= read_result_next;
            ack_out_reg  <= ack_level_next;
            rejected_reg <= rej_c;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_scl_out      = scl_out_reg;
    assign m_sda_out      = sda_out_reg;
    assign m_busy_res     = busy_reg;
    assign m_done_res     = done_reg;
    assign m_rx_byte      = rx_byte_reg;
    assign m_ack_received = ack_out_reg;
    assign m_rejected     = rejected_reg;

    `I2CM_ASSERT_IMPL(a_bit_bound, aclk, aresetn, 1'b1, bit_index_reg <= ACK_SLOT)
    `I2CM_ASSERT_IMPL(a_idle_bit_zero, aclk, aresetn, phase_reg == PH_IDLE, bit_index_reg == 4'd0)
    `I2CM_ASSERT_NEXT(a_accept_result, aclk, aresetn, s_valid && s_ready, m_valid)
    `I2CM_ASSERT_IMPL(a_done_not_busy, aclk, aresetn, m_valid && m_done_res, !m_busy_res)

endmodule
